// ===== rtl/core/wsfr_pkg.sv =====
// Package for the frame receiver: parser phases, opcodes, event codes and register map.
package wsfr_pkg;

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_MASK = 6'b001000,
        PH_PAY  = 6'b010000,
        PH_STOP = 6'b100000
    } phase_t;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'ha;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_TEXT_BYTE = 3'd1;
    localparam logic [2:0] EV_TEXT_END  = 3'd2;
    localparam logic [2:0] EV_TEXT_RST  = 3'd3;
    localparam logic [2:0] EV_PING_BYTE = 3'd4;
    localparam logic [2:0] EV_PING_NULL = 3'd5;
    localparam logic [2:0] EV_CLOSE     = 3'd6;
    localparam logic [2:0] EV_TOO_LARGE = 3'd7;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;
    localparam logic [2:0] MASK_LEFT  = 3'd3;

    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_MAX_PAYLOAD = 3'd0;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd8388608;

endpackage

// ===== rtl/core/websocket_frame_receiver.sv =====
// Frame receiver top level: header parser, payload unmasker and result register.
//
// Takes one received byte per transaction and gives at most one result per byte.
// A byte is taken in every cycle in which the input is not stalled: the whole header
// and payload step for a byte is done in the cycle it is accepted, and its result
// lands in a one-entry output register. The input stalls only while that
// register holds a result that the output side is stalling. After a close frame
// or an oversize length every further byte is consumed and ignored until reset.
// max_payload sits at byte address 0 of the APB port.
module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        event_res,
    output logic [7:0]        data,
    output logic              first,
    output logic              last
);

    logic [31:0] max_payload_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  ext_left_reg, ext_left_next;
    logic        frame_final_reg, frame_final_next;
    logic [3:0]  frame_kind_reg, frame_kind_next;
    logic        has_mask_reg, has_mask_next;
    logic [63:0] length_left_reg, length_left_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  mask_phase_reg, mask_phase_next;
    logic [3:0]  msg_kind_reg, msg_kind_next;
    logic        msg_has_reg, msg_has_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  event_reg, event_next;
    logic [7:0]  data_reg, data_next;
    logic        first_reg, first_next;
    logic        last_reg, last_next;

    logic        in_accept;
    logic        out_accept;
    logic        emit;
    logic [2:0]  ev;
    logic [7:0]  ev_data;
    logic        ev_first;
    logic        ev_last;
    logic        do_len_known;
    logic        do_hdr_done;
    logic [63:0] len_val;
    logic        len_empty;
    logic [3:0]  kind_eff;
    logic        has_eff;
    logic [7:0]  key_byte;
    logic [7:0]  pay_data;
    logic [63:0] len_dec;
    logic        pay_end;

    assign pready     = 1'b1;
    assign prdata     = (paddr == ADDR_MAX_PAYLOAD) ? max_payload_reg : 32'd0;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign data       = data_reg;
    assign first      = first_reg;
    assign last       = last_reg;

    always_comb
    begin
        unique case (mask_phase_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    assign pay_data = has_mask_reg ? (rx_byte ^ key_byte) : rx_byte;
    assign len_dec  = length_left_reg - 64'd1;
    assign pay_end  = (length_left_reg == 64'd1);

    always_comb
    begin
        phase_next       = phase_reg;
        ext_left_next    = ext_left_reg;
        frame_final_next = frame_final_reg;
        frame_kind_next  = frame_kind_reg;
        has_mask_next    = has_mask_reg;
        length_left_next = length_left_reg;
        mask_key_next    = mask_key_reg;
        mask_phase_next  = mask_phase_reg;
        msg_kind_next    = msg_kind_reg;
        msg_has_next     = msg_has_reg;
        emit             = 1'b0;
        ev               = EV_NONE;
        ev_data          = 8'd0;
        ev_first         = 1'b0;
        ev_last          = 1'b0;
        do_len_known     = 1'b0;
        do_hdr_done      = 1'b0;
        len_val          = length_left_reg;
        len_empty        = 1'b0;
        kind_eff         = msg_kind_reg;
        has_eff          = msg_has_reg;

        unique case (phase_reg)
            PH_HDR0:
            begin
                frame_final_next = rx_byte[7];
                frame_kind_next  = rx_byte[3:0];
                phase_next       = PH_HDR1;
            end
            PH_HDR1:
            begin
                has_mask_next    = rx_byte[7];
                length_left_next = 64'd0;
                if (rx_byte[6:0] == LEN_EXT16)
                begin
                    ext_left_next = EXT16_LEFT;
                    phase_next    = PH_EXT;
                end
                else if (rx_byte[6:0] == LEN_EXT64)
                begin
                    ext_left_next = EXT64_LEFT;
                    phase_next    = PH_EXT;
                end
                else
                begin
                    len_val          = {57'd0, rx_byte[6:0]};
                    length_left_next = len_val;
                    do_len_known     = 1'b1;
                end
            end
            PH_EXT:
            begin
                len_val          = {length_left_reg[55:0], rx_byte};
                length_left_next = len_val;
                if (ext_left_reg == 3'd0)
                    do_len_known = 1'b1;
                else
                    ext_left_next = ext_left_reg - 3'd1;
            end
            PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], rx_byte};
                if (ext_left_reg == 3'd0)
                    do_hdr_done = 1'b1;
                else
                    ext_left_next = ext_left_reg - 3'd1;
            end
            PH_PAY:
            begin
                mask_phase_next  = mask_phase_reg + 2'd1;
                length_left_next = len_dec;
                if (pay_end)
                    phase_next = PH_HDR0;
                if (frame_kind_reg == OP_CLOSE)
                begin
                    if (pay_end)
                    begin
                        phase_next = PH_STOP;
                        emit       = 1'b1;
                        ev         = EV_CLOSE;
                    end
                end
                else if (frame_kind_reg == OP_PING)
                begin
                    emit    = 1'b1;
                    ev      = EV_PING_BYTE;
                    ev_data = pay_data;
                    ev_last = pay_end;
                end
                else if (frame_kind_reg == OP_PONG)
                begin
                    emit = 1'b0;
                end
                else if (msg_kind_reg == OP_TEXT)
                begin
                    emit         = 1'b1;
                    ev           = EV_TEXT_BYTE;
                    ev_data      = pay_data;
                    ev_first     = !msg_has_reg;
                    ev_last      = pay_end && frame_final_reg;
                    msg_has_next = !(pay_end && frame_final_reg);
                end
            end
            PH_STOP:
            begin
                phase_next = PH_STOP;
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        if (do_len_known)
        begin
            if (len_val > {32'd0, max_payload_reg})
            begin
                phase_next = PH_STOP;
                emit       = 1'b1;
                ev         = EV_TOO_LARGE;
            end
            else if (has_mask_next)
            begin
                phase_next    = PH_MASK;
                ext_left_next = MASK_LEFT;
                mask_key_next = 32'd0;
            end
            else
            begin
                do_hdr_done = 1'b1;
            end
        end

        if (do_hdr_done)
        begin
            len_empty       = (len_val == 64'd0);
            mask_phase_next = 2'd0;
            phase_next      = len_empty ? PH_HDR0 : PH_PAY;
            if (frame_kind_reg == OP_CLOSE)
            begin
                if (len_empty)
                begin
                    phase_next = PH_STOP;
                    emit       = 1'b1;
                    ev         = EV_CLOSE;
                end
            end
            else if (frame_kind_reg == OP_PING)
            begin
                if (len_empty)
                begin
                    emit = 1'b1;
                    ev   = EV_PING_NULL;
                end
            end
            else if (frame_kind_reg != OP_PONG)
            begin
                if (frame_kind_reg != OP_CONT)
                begin
                    msg_kind_next = frame_kind_reg;
                    kind_eff      = frame_kind_reg;
                    if (frame_kind_reg == OP_TEXT)
                        has_eff = 1'b0;
                end
                if (frame_kind_reg != OP_CONT && frame_kind_reg != OP_TEXT && msg_has_reg)
                begin
                    msg_has_next = 1'b0;
                    emit         = 1'b1;
                    ev           = EV_TEXT_RST;
                end
                else
                begin
                    msg_has_next = has_eff;
                    if (kind_eff == OP_TEXT && len_empty && frame_final_reg)
                    begin
                        msg_has_next = 1'b0;
                        emit         = 1'b1;
                        ev           = EV_TEXT_END;
                        ev_first     = !has_eff;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        event_next     = event_reg;
        data_next      = data_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        if (out_accept)
            out_valid_next = 1'b0;
        if (in_accept && emit)
        begin
            out_valid_next = 1'b1;
            event_next     = ev;
            data_next      = ev_data;
            first_next     = ev_first;
            last_next      = ev_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_PAYLOAD)
        begin
            max_payload_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            ext_left_reg    <= 3'd0;
            frame_final_reg <= 1'b0;
            frame_kind_reg  <= OP_CONT;
            has_mask_reg    <= 1'b0;
            length_left_reg <= 64'd0;
            mask_key_reg    <= 32'd0;
            mask_phase_reg  <= 2'd0;
            msg_kind_reg    <= OP_CONT;
            msg_has_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg       <= phase_next;
                ext_left_reg    <= ext_left_next;
                frame_final_reg <= frame_final_next;
                frame_kind_reg  <= frame_kind_next;
                has_mask_reg    <= has_mask_next;
                length_left_reg <= length_left_next;
                mask_key_reg    <= mask_key_next;
                mask_phase_reg  <= mask_phase_next;
                msg_kind_reg    <= msg_kind_next;
                msg_has_reg     <= msg_has_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg <= event_next;
        data_reg  <= data_next;
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_STOP |=> phase_reg == PH_STOP)
        else $error("parser left the stopped phase");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty result register");

    a_first_text_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && first_reg |->
            (event_reg == EV_TEXT_BYTE || event_reg == EV_TEXT_END))
        else $error("first mark on a non-text event");

    a_terminal_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (event_reg == EV_CLOSE || event_reg == EV_TOO_LARGE)
            |-> phase_reg == PH_STOP)
        else $error("terminal event without a stopped parser");

endmodule
